### rtl/lz_token_gamma_bit_encoder_unit_assert.svh
// Assertion helpers for the token encoder. They sample on clk and are
// disabled while arst_n is low, so a module that uses them needs both names.
`ifndef LZ_TOKEN_GAMMA_BIT_ENCODER_UNIT_ASSERT_SVH
`define LZ_TOKEN_GAMMA_BIT_ENCODER_UNIT_ASSERT_SVH

// The consequence must hold in the same cycle as the antecedent.
`define LZTG_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lztg: same-cycle check failed in %m");

// The consequence must hold in the cycle after the antecedent.
`define LZTG_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lztg: next-cycle check failed in %m");

`endif

### rtl/lztg_pkg.sv
package lztg_pkg;

	localparam logic [1:0] CMD_LIT_BYTE = 2'd0;
	localparam logic [1:0] CMD_LIT_RUN  = 2'd1;
	localparam logic [1:0] CMD_MATCH    = 2'd2;
	localparam logic [1:0] CMD_END      = 2'd3;

	localparam logic KIND_BITS = 1'b0;
	localparam logic KIND_RAW  = 1'b1;

	localparam int CHUNK_W = 40;
	localparam int NBITS_W = 6;

	localparam logic [NBITS_W-1:0] RAW_NBITS = 6'd8;
	// Longest bit chunk: type bit, separator and a 31-bit gamma code.
	localparam logic [NBITS_W-1:0] MAX_CHUNK_NBITS = 6'd33;

	// End marker: a 1, then fourteen (1,0) pairs, then (1,1).
	localparam logic [CHUNK_W-1:0] END_CHUNK = 40'h00_6AAA_AAAB;
	localparam logic [NBITS_W-1:0] END_NBITS = 6'd31;

	typedef struct packed {
		logic               kind;
		logic [CHUNK_W-1:0] chunk;
		logic [NBITS_W-1:0] nbits;
	} result_t;

endpackage

### rtl/lz_token_gamma_bit_encoder_unit.sv
// A token accepted into the input register moves on to the result register, which drives the output.
// Throughput: one token per cycle unless stalled by out_ready or by a match's three results.
// An input register and a result register part the two sides, so a new token is taken
// while the previous results still wait at the output.
// Reset clears both valid flags, the result index and omit_type_bit (alternate format off).
module lz_token_gamma_bit_encoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [15:0] run_length,
	input  logic [14:0] back_offset,
	input  logic [7:0]  byte_value,
	input  logic        is_first,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [39:0] chunk,
	output logic [5:0]  chunk_bits,
	output logic        last
);

	typedef struct packed {
		logic [30:0] code;
		logic [4:0]  len;
	} gamma_t;

	localparam logic [1:0] LAST_IDX = 2'd2;

	// Interlaced gamma: data bit k of the value below its leading one lands at
	// code bit 2k+1, the closing 1 at bit 0, and the 0 flags at the even bits.
	function automatic gamma_t gamma_code(input logic [15:0] value, input logic skip);
		logic [3:0]  p;
		logic [15:0] low;
		logic [15:0] w;
		gamma_t      g;
		p = 4'd0;
		for (int i = 1; i < 16; i++) begin
			if (value[i]) begin
				p = 4'(i);
			end
		end
		low = value & ((16'd1 << p) - 16'd1);
		if (p >= 4'd8) begin
			// Long values send their low eight bits first.
			w = (low >> 8) | ((low & 16'h00ff) << (p - 4'd8));
		end else begin
			w = low;
		end
		g.code = '0;
		g.code[0] = 1'b1;
		for (int k = 0; k < 15; k++) begin
			g.code[2*k+1] = w[k];
		end
		g.len = {p, 1'b1};
		if (skip) begin
			// Dropping the leading 0 flag leaves the value unchanged.
			if (p == 4'd0) begin
				g.code = '0;
				g.len  = 5'd0;
			end else begin
				g.len = {p, 1'b0};
			end
		end
		return g;
	endfunction

	logic        omit_type_bit_q;

	logic        valid_s1;
	logic [1:0]  cmd_s1;
	logic [15:0] run_length_s1;
	logic [14:0] back_offset_s1;
	logic [7:0]  byte_value_s1;
	logic        is_first_s1;

	logic                valid_s2;
	lztg_pkg::result_t   res_s2 [3];
	logic                multi_s2;
	logic [1:0]          idx_q;

	logic                out_fire;
	logic                done;
	logic                s2_load;

	logic [14:0]         om1;
	logic [8:0]          off_hi;
	gamma_t              g_off;
	gamma_t              g_len;
	gamma_t              g_run;
	logic [1:0]          pre_val;
	logic [1:0]          pre_len;
	lztg_pkg::result_t   res_d [3];
	logic                multi_d;

	assign out_fire = valid_s2 && out_ready;
	assign done     = out_fire && last;
	assign s2_load  = valid_s1 && (!valid_s2 || done);
	assign in_ready = !valid_s1 || s2_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			omit_type_bit_q <= 1'b0;
		end else if (cfg_we) begin
			omit_type_bit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1         <= cmd;
			run_length_s1  <= run_length;
			back_offset_s1 <= back_offset;
			byte_value_s1  <= byte_value;
			is_first_s1    <= is_first;
		end
	end

	// Match offset splits into a gamma-coded high part and a raw part of its low seven bits.
	// An offset of zero wraps to the largest distance.
	assign om1    = back_offset_s1 - 15'd1;
	assign off_hi = {1'b0, om1[14:7]} + 9'd1;
	assign g_off  = gamma_code({7'd0, off_hi}, 1'b0);
	assign g_len  = gamma_code(run_length_s1 - 16'd1, 1'b1);
	assign g_run  = gamma_code(run_length_s1, 1'b0);

	always_comb begin
		case ({omit_type_bit_q, is_first_s1})
			2'b00:   begin pre_val = 2'b10; pre_len = 2'd2; end
			2'b01:   begin pre_val = 2'b01; pre_len = 2'd1; end
			2'b10:   begin pre_val = 2'b00; pre_len = 2'd1; end
			default: begin pre_val = 2'b00; pre_len = 2'd0; end
		endcase
	end

	always_comb begin
		res_d[1].kind  = lztg_pkg::KIND_RAW;
		res_d[1].chunk = {32'd0, om1[6:0], (run_length_s1 == 16'd2)};
		res_d[1].nbits = lztg_pkg::RAW_NBITS;
		res_d[2].kind  = lztg_pkg::KIND_BITS;
		res_d[2].chunk = {9'd0, g_len.code};
		res_d[2].nbits = {1'b0, g_len.len};
		multi_d        = 1'b0;
		case (cmd_s1)
			lztg_pkg::CMD_LIT_BYTE: begin
				res_d[0].kind  = lztg_pkg::KIND_RAW;
				res_d[0].chunk = {32'd0, byte_value_s1};
				res_d[0].nbits = lztg_pkg::RAW_NBITS;
			end
			lztg_pkg::CMD_LIT_RUN: begin
				res_d[0].kind  = lztg_pkg::KIND_BITS;
				res_d[0].chunk = ({38'd0, pre_val} << g_run.len) | {9'd0, g_run.code};
				res_d[0].nbits = {4'd0, pre_len} + {1'b0, g_run.len};
			end
			lztg_pkg::CMD_MATCH: begin
				res_d[0].kind  = lztg_pkg::KIND_BITS;
				res_d[0].chunk = (40'd1 << g_off.len) | {9'd0, g_off.code};
				res_d[0].nbits = {1'b0, g_off.len} + 6'd1;
				multi_d        = 1'b1;
			end
			default: begin
				res_d[0].kind  = lztg_pkg::KIND_BITS;
				res_d[0].chunk = lztg_pkg::END_CHUNK;
				res_d[0].nbits = lztg_pkg::END_NBITS;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= 2'd0;
		end else if (s2_load) begin
			valid_s2 <= 1'b1;
			idx_q    <= 2'd0;
		end else if (done) begin
			valid_s2 <= 1'b0;
		end else if (out_fire) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_load) begin
			res_s2[0] <= res_d[0];
			res_s2[1] <= res_d[1];
			res_s2[2] <= res_d[2];
			multi_s2  <= multi_d;
		end
	end

	assign out_valid  = valid_s2;
	assign kind       = res_s2[idx_q].kind;
	assign chunk      = res_s2[idx_q].chunk;
	assign chunk_bits = res_s2[idx_q].nbits;
	assign last       = !multi_s2 || (idx_q == LAST_IDX);

endmodule

### rtl/lztg_checker.sv
`include "lz_token_gamma_bit_encoder_unit_assert.svh"

module lztg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        kind,
	input logic [39:0] chunk,
	input logic [5:0]  chunk_bits,
	input logic        last
);

	// A result that is not taken stays on the port unchanged.
	`LZTG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(kind) && $stable(chunk) && $stable(chunk_bits) && $stable(last))

	// A raw byte is always eight bits wide with nothing above the byte.
	`LZTG_ASSERT_NOW(a_raw_byte, out_valid && (kind == lztg_pkg::KIND_RAW), (chunk_bits == lztg_pkg::RAW_NBITS) && (chunk[39:8] == 32'd0))

	// No bit chunk is longer than a full literal header.
	`LZTG_ASSERT_NOW(a_chunk_len, out_valid && (kind == lztg_pkg::KIND_BITS), chunk_bits <= lztg_pkg::MAX_CHUNK_NBITS)

	// The rest of a token's results follow without a gap.
	`LZTG_ASSERT_NEXT(a_no_gap, out_valid && out_ready && !last, out_valid)

endmodule

bind lz_token_gamma_bit_encoder_unit lztg_checker u_lztg_checker (.*);
